@@ rtl/core/ffra_pkg.sv @@
// Shared types, sizes and codes for the first-fit range allocator.
package ffra_pkg;

  localparam int FREE_ENTRIES = 64;
  localparam int USED_ENTRIES = 64;
  localparam int ADDR_W       = 32;
  localparam int HANDLE_W     = 64;
  localparam int FE_IW        = $clog2(FREE_ENTRIES);
  localparam int FE_CW        = $clog2(FREE_ENTRIES + 1);
  localparam int UE_IW        = $clog2(USED_ENTRIES);
  localparam int UE_CW        = $clog2(USED_ENTRIES + 1);
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_INDEX  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 1'b1;

  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_FREE   = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TYPE     = 3'd1;
  localparam logic [2:0] ST_LARGE    = 3'd2;
  localparam logic [2:0] ST_OOM      = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [HANDLE_W-1:0] handle;
    logic [31:0]         size;
    logic [31:0]         alignment;
    logic [31:0]         type_bits;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] offset;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] size;
  } free_ent_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [ADDR_W-1:0]   off;
    logic [ADDR_W-1:0]   size;
  } used_ent_t;

  typedef enum logic [4:0] {
    S_IDLE, S_US_RD, S_US_CHK, S_DISP,
    S_FA_RD, S_FA_START, S_FA_WAIT, S_AL_CHECK, S_AL_GAP,
    S_FF_RD, S_FF_CHK, S_FR_APPLY,
    S_RM_RD, S_RM_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] dividend;
    logic [ADDR_W-1:0] divisor;
  } mod_req_t;

endpackage

@@ rtl/core/ffra_ram.sv @@
// Generic single write port, single read port RAM with registered read.
module ffra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/ffra_mod_unit.sv @@
// Bit-serial remainder unit: one quotient bit per cycle.
module ffra_mod_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ffra_pkg::mod_req_t       req,
  output logic                     done,
  output logic [ffra_pkg::ADDR_W-1:0] rem
);
  import ffra_pkg::*;

  localparam int CW = $clog2(ADDR_W);

  logic [ADDR_W-1:0] rem_r, rem_nxt;
  logic [ADDR_W-1:0] dvd_r, dvd_nxt;
  logic [ADDR_W-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [ADDR_W:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[ADDR_W-1]};
    if (req.start) begin
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = ADDR_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[ADDR_W-1:0];
      end
      dvd_nxt = {dvd_r[ADDR_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(ADDR_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

@@ rtl/core/first_fit_range_allocator.sv @@
// First-fit range allocator: free list and used table in RAM, sequencer on top.
// Sequencing: the used table is searched entry by entry, then the free list is
// walked, with a serial remainder per free entry for allocate; closing a gap in
// the list shifts later entries one at a time; one beat at a time.
// Reset: used table empty, free list one range {0, 0}, config registers zero; no sweep.
module first_fit_range_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ffra_pkg::req_t                 in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ffra_pkg::rsp_t                 out_data,
  input  logic                           cfg_we,
  input  logic [ffra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata
);
  import ffra_pkg::*;

  state_t            state_r, state_nxt;
  req_t              req_r, req_nxt;
  logic [4:0]        type_index_r, type_index_nxt;
  logic [31:0]       block_bytes_r, block_bytes_nxt;
  logic              e0_ovr_r, e0_ovr_nxt;
  logic              rd0_r;
  logic [FE_CW-1:0]  free_count_r, free_count_nxt;
  logic [USED_ENTRIES-1:0] used_valid_r, used_valid_nxt;

  logic [UE_CW-1:0]  uidx_r, uidx_nxt;
  logic              ufound_r, ufound_nxt;
  logic [UE_IW-1:0]  uslot_r, uslot_nxt;
  logic              uempty_ok_r, uempty_ok_nxt;
  logic [UE_IW-1:0]  uempty_r, uempty_nxt;
  logic [ADDR_W-1:0] u_off_r, u_off_nxt;
  logic [ADDR_W-1:0] u_size_r, u_size_nxt;

  logic [FE_CW-1:0]  fidx_r, fidx_nxt;
  logic [FE_IW-1:0]  fhit_r, fhit_nxt;
  logic [ADDR_W-1:0] fo_r, fo_nxt;
  logic [ADDR_W-1:0] fs_r, fs_nxt;
  logic [ADDR_W-1:0] gap_r, gap_nxt;
  logic              hl_r, hl_nxt, hr_r, hr_nxt;
  logic [FE_IW-1:0]  li_r, li_nxt, ri_r, ri_nxt;
  logic [ADDR_W-1:0] lo_r, lo_nxt, ro_r, ro_nxt, rs_r, rs_nxt;
  logic [FE_CW-1:0]  rmj_r, rmj_nxt;

  logic [2:0]        status_r, status_nxt;
  logic [ADDR_W-1:0] offset_r, offset_nxt;
  logic              out_valid_r, out_valid_nxt;
  rsp_t              out_data_r, out_data_nxt;

  logic              f_we;
  logic [FE_IW-1:0]  f_waddr, f_raddr;
  free_ent_t         f_wdata, f_q, f_rd;
  logic              u_we;
  logic [UE_IW-1:0]  u_waddr, u_raddr;
  used_ent_t         u_wdata, u_rd;

  mod_req_t          mreq;
  logic              m_done;
  logic [ADDR_W-1:0] m_rem;

  logic [ADDR_W-1:0] align_eff, g, u_end, aligned;
  logic              fit, exact;

  ffra_ram #(.WIDTH($bits(free_ent_t)), .DEPTH(FREE_ENTRIES)) u_free_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_q)
  );

  ffra_ram #(.WIDTH($bits(used_ent_t)), .DEPTH(USED_ENTRIES)) u_used_ram (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .raddr(u_raddr), .rdata(u_rd)
  );

  ffra_mod_unit u_mod (
    .clk(clk), .rst_n(rst_n), .req(mreq), .done(m_done), .rem(m_rem)
  );

  // Entry 0 reads as the full block after reset or a block-size write, until the engine rewrites it.
  assign f_rd = (rd0_r && e0_ovr_r) ? free_ent_t'{off: '0, size: block_bytes_r} : f_q;

  assign align_eff = (req_r.alignment == '0) ? ADDR_W'(1) : req_r.alignment;
  assign g         = (m_rem != '0) ? align_eff - m_rem : '0;
  assign fit       = (g <= fs_r) && (req_r.size <= fs_r - g);
  assign exact     = ({1'b0, gap_r} + {1'b0, req_r.size}) == {1'b0, fs_r};
  assign aligned   = fo_r + gap_r;
  assign u_end     = u_off_r + u_size_r;

  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    type_index_nxt  = type_index_r;
    block_bytes_nxt = block_bytes_r;
    e0_ovr_nxt      = e0_ovr_r;
    free_count_nxt  = free_count_r;
    used_valid_nxt  = used_valid_r;
    uidx_nxt        = uidx_r;
    ufound_nxt      = ufound_r;
    uslot_nxt       = uslot_r;
    uempty_ok_nxt   = uempty_ok_r;
    uempty_nxt      = uempty_r;
    u_off_nxt       = u_off_r;
    u_size_nxt      = u_size_r;
    fidx_nxt        = fidx_r;
    fhit_nxt        = fhit_r;
    fo_nxt          = fo_r;
    fs_nxt          = fs_r;
    gap_nxt         = gap_r;
    hl_nxt          = hl_r;
    hr_nxt          = hr_r;
    li_nxt          = li_r;
    ri_nxt          = ri_r;
    lo_nxt          = lo_r;
    ro_nxt          = ro_r;
    rs_nxt          = rs_r;
    rmj_nxt         = rmj_r;
    status_nxt      = status_r;
    offset_nxt      = offset_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    f_we            = 1'b0;
    f_waddr         = '0;
    f_wdata         = '0;
    f_raddr         = '0;
    u_we            = 1'b0;
    u_waddr         = uempty_r;
    u_wdata         = used_ent_t'{handle: req_r.handle, off: aligned, size: req_r.size};
    u_raddr         = uidx_r[UE_IW-1:0];
    mreq            = '0;
    in_ready        = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_index)
        CFG_TYPE_INDEX: type_index_nxt = cfg_wdata[4:0];
        CFG_BLOCK_BYTES: begin
          block_bytes_nxt = cfg_wdata;
          e0_ovr_nxt      = 1'b1;
          free_count_nxt  = FE_CW'(1);
        end
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt       = in_data;
          uidx_nxt      = '0;
          ufound_nxt    = 1'b0;
          uempty_ok_nxt = 1'b0;
          offset_nxt    = '0;
          state_nxt     = S_US_RD;
        end
      end
      S_US_RD: begin
        state_nxt = S_US_CHK;
      end
      S_US_CHK: begin
        if (used_valid_r[uidx_r[UE_IW-1:0]]) begin
          if (!ufound_r && u_rd.handle == req_r.handle) begin
            ufound_nxt = 1'b1;
            uslot_nxt  = uidx_r[UE_IW-1:0];
            u_off_nxt  = u_rd.off;
            u_size_nxt = u_rd.size;
          end
        end else if (!uempty_ok_r) begin
          uempty_ok_nxt = 1'b1;
          uempty_nxt    = uidx_r[UE_IW-1:0];
        end
        uidx_nxt = uidx_r + 1'b1;
        if (uidx_r == UE_CW'(USED_ENTRIES - 1)) begin
          state_nxt = S_DISP;
        end else begin
          state_nxt = S_US_RD;
        end
      end
      S_DISP: begin
        fidx_nxt = '0;
        hl_nxt   = 1'b0;
        hr_nxt   = 1'b0;
        case (req_r.req_type)
          REQ_ALLOC: begin
            if (!req_r.type_bits[type_index_r]) begin
              status_nxt = ST_TYPE;
              state_nxt  = S_DONE;
            end else if (req_r.size > block_bytes_r) begin
              status_nxt = ST_LARGE;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_FA_RD;
            end
          end
          REQ_FREE: begin
            if (!ufound_r) begin
              status_nxt = ST_NOTFOUND;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_FF_RD;
            end
          end
          REQ_LOOKUP: begin
            status_nxt = ufound_r ? ST_OK : ST_NOTFOUND;
            offset_nxt = u_off_r;
            state_nxt  = S_DONE;
          end
          default: begin
            status_nxt = ST_NOTFOUND;
            state_nxt  = S_DONE;
          end
        endcase
      end
      S_FA_RD: begin
        f_raddr = fidx_r[FE_IW-1:0];
        if (fidx_r == free_count_r) begin
          status_nxt = ST_OOM;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_FA_START;
        end
      end
      S_FA_START: begin
        fo_nxt        = f_rd.off;
        fs_nxt        = f_rd.size;
        mreq.start    = 1'b1;
        mreq.dividend = f_rd.off;
        mreq.divisor  = align_eff;
        state_nxt     = S_FA_WAIT;
      end
      S_FA_WAIT: begin
        if (m_done) begin
          if (fit) begin
            fhit_nxt  = fidx_r[FE_IW-1:0];
            gap_nxt   = g;
            state_nxt = S_AL_CHECK;
          end else begin
            fidx_nxt  = fidx_r + 1'b1;
            state_nxt = S_FA_RD;
          end
        end
      end
      S_AL_CHECK: begin
        if (!ufound_r && !uempty_ok_r) begin
          status_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end else if (!exact && gap_r != '0 && free_count_r == FE_CW'(FREE_ENTRIES)) begin
          status_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          status_nxt = ST_OK;
          offset_nxt = aligned;
          if (!ufound_r) begin
            u_we                      = 1'b1;
            used_valid_nxt[uempty_r]  = 1'b1;
          end
          if (exact && gap_r == '0) begin
            rmj_nxt   = FE_CW'(fhit_r);
            state_nxt = S_RM_RD;
          end else if (exact) begin
            f_we      = 1'b1;
            f_waddr   = fhit_r;
            f_wdata   = free_ent_t'{off: fo_r, size: gap_r};
            state_nxt = S_DONE;
          end else begin
            f_we      = 1'b1;
            f_waddr   = fhit_r;
            f_wdata   = free_ent_t'{off: aligned + req_r.size,
                                    size: fs_r - gap_r - req_r.size};
            state_nxt = (gap_r != '0) ? S_AL_GAP : S_DONE;
          end
        end
      end
      S_AL_GAP: begin
        // append the front gap at the list end
        f_we           = 1'b1;
        f_waddr        = free_count_r[FE_IW-1:0];
        f_wdata        = free_ent_t'{off: fo_r, size: gap_r};
        free_count_nxt = free_count_r + 1'b1;
        state_nxt      = S_DONE;
      end
      S_FF_RD: begin
        f_raddr = fidx_r[FE_IW-1:0];
        if (fidx_r == free_count_r || (hl_r && hr_r)) begin
          state_nxt = S_FR_APPLY;
        end else begin
          state_nxt = S_FF_CHK;
        end
      end
      S_FF_CHK: begin
        if (f_rd.off == u_end) begin
          hr_nxt = 1'b1;
          ri_nxt = fidx_r[FE_IW-1:0];
          ro_nxt = f_rd.off;
          rs_nxt = f_rd.size;
        end else if (f_rd.off + f_rd.size == u_off_r) begin
          hl_nxt = 1'b1;
          li_nxt = fidx_r[FE_IW-1:0];
          lo_nxt = f_rd.off;
        end
        fidx_nxt  = fidx_r + 1'b1;
        state_nxt = S_FF_RD;
      end
      S_FR_APPLY: begin
        status_nxt = ST_OK;
        offset_nxt = '0;
        state_nxt  = S_DONE;
        if (hr_r && hl_r) begin
          f_we      = 1'b1;
          f_waddr   = ri_r;
          f_wdata   = free_ent_t'{off: lo_r, size: ro_r + rs_r - lo_r};
          rmj_nxt   = FE_CW'(li_r);
          state_nxt = S_RM_RD;
        end else if (hr_r) begin
          f_we    = 1'b1;
          f_waddr = ri_r;
          f_wdata = free_ent_t'{off: u_off_r, size: ro_r + rs_r - u_off_r};
        end else if (hl_r) begin
          f_we    = 1'b1;
          f_waddr = li_r;
          f_wdata = free_ent_t'{off: lo_r, size: u_end - lo_r};
        end else if (free_count_r == FE_CW'(FREE_ENTRIES)) begin
          status_nxt = ST_FULL;
        end else begin
          f_we           = 1'b1;
          f_waddr        = free_count_r[FE_IW-1:0];
          f_wdata        = free_ent_t'{off: u_off_r, size: u_size_r};
          free_count_nxt = free_count_r + 1'b1;
        end
        if (status_nxt == ST_OK) begin
          used_valid_nxt[uslot_r] = 1'b0;
        end
      end
      S_RM_RD: begin
        // shift later entries up one place
        f_raddr = FE_IW'(rmj_r + 1'b1);
        if (FE_CW'(rmj_r + 1'b1) >= free_count_r) begin
          free_count_nxt = free_count_r - 1'b1;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_RM_WR;
        end
      end
      S_RM_WR: begin
        f_we      = 1'b1;
        f_waddr   = rmj_r[FE_IW-1:0];
        f_wdata   = f_rd;
        rmj_nxt   = rmj_r + 1'b1;
        state_nxt = S_RM_RD;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = status_r;
          out_data_nxt.offset = (status_r == ST_OK) ? offset_r : '0;
          state_nxt           = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (f_we && f_waddr == '0) begin
      e0_ovr_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      type_index_r  <= '0;
      block_bytes_r <= '0;
      e0_ovr_r      <= 1'b1;
      free_count_r  <= FE_CW'(1);
      used_valid_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      type_index_r  <= type_index_nxt;
      block_bytes_r <= block_bytes_nxt;
      e0_ovr_r      <= e0_ovr_nxt;
      free_count_r  <= free_count_nxt;
      used_valid_r  <= used_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    rd0_r       <= (f_raddr == '0);
    req_r       <= req_nxt;
    uidx_r      <= uidx_nxt;
    ufound_r    <= ufound_nxt;
    uslot_r     <= uslot_nxt;
    uempty_ok_r <= uempty_ok_nxt;
    uempty_r    <= uempty_nxt;
    u_off_r     <= u_off_nxt;
    u_size_r    <= u_size_nxt;
    fidx_r      <= fidx_nxt;
    fhit_r      <= fhit_nxt;
    fo_r        <= fo_nxt;
    fs_r        <= fs_nxt;
    gap_r       <= gap_nxt;
    hl_r        <= hl_nxt;
    hr_r        <= hr_nxt;
    li_r        <= li_nxt;
    ri_r        <= ri_nxt;
    lo_r        <= lo_nxt;
    ro_r        <= ro_nxt;
    rs_r        <= rs_nxt;
    rmj_r       <= rmj_nxt;
    status_r    <= status_nxt;
    offset_r    <= offset_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
